FILE: src/chte_pkg.sv
// package: shared types and constants for the chained hash table engine
`timescale 1ns / 1ps
package chte_pkg;

   localparam int DEF_NUM_BUCKETS  = 256;
   localparam int DEF_POOL_ENTRIES = 256;
   localparam int DEF_KEY_BITS     = 64;
   localparam int DEF_VALUE_BITS   = 32;

   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [1:0] {
      FUNC_GET    = 2'd0,
      FUNC_SET    = 2'd1,
      FUNC_REMOVE = 2'd2,
      FUNC_NOP    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STAT_HIT  = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2,
      STAT_RSVD = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_HEAD,
      ST_READ,
      ST_CHECK,
      ST_ALLOC,
      ST_INSERT,
      ST_UNLINK,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic init_step;   // write one init row
      logic load;        // capture request
      logic head_rd;     // read bucket head
      logic ent_rd;      // read entry at cur
      logic advance;     // cur <= next, prev <= cur
      logic upd_value;   // replace value at cur
      logic alloc;       // pop free list, write new entry, set head
      logic unlink;      // unlink cur, push on free list
      logic set_hit;     // status hit, value from entry
      logic set_hit0;    // status hit, value zero
      logic set_full;    // status full
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic   init_done;
      logic   cur_valid;
      logic   key_match;
      logic   val_match;
      logic   free_valid;
      logic   steps_done;
      logic [1:0] func;
   } sts_type;

endpackage

FILE: src/chte_ctrl.sv
// controller: sequences init sweep, chain walk and table updates
`timescale 1ns / 1ps
module chte_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  chte_pkg::sts_type  sts,
   output chte_pkg::cmd_type  cmd
);
   import chte_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_INIT;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT:  if (sts.init_done) state_in = ST_IDLE;
         ST_IDLE:  if (req_valid) state_in = ST_HEAD;
         ST_HEAD:  begin
            if (sts.func == FUNC_NOP) state_in = ST_RESP;
            else                      state_in = ST_READ;
         end
         ST_READ:  begin
            if (!sts.cur_valid || sts.steps_done) begin
               if (sts.func == FUNC_SET) state_in = ST_ALLOC;
               else                      state_in = ST_RESP;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.func == FUNC_REMOVE) begin
               state_in = sts.val_match ? ST_UNLINK : ST_READ;
            end else begin
               state_in = sts.key_match ? ST_RESP : ST_READ;
            end
         end
         ST_ALLOC: state_in = sts.free_valid ? ST_INSERT : ST_RESP;
         ST_INSERT: state_in = ST_RESP;
         ST_UNLINK: state_in = ST_RESP;
         ST_RESP:  if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT:  cmd.init_step = 1'b1;
         ST_IDLE:  begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_HEAD:  cmd.head_rd = 1'b1;
         ST_READ:  cmd.ent_rd = sts.cur_valid && !sts.steps_done;
         ST_CHECK: begin
            if (sts.func == FUNC_REMOVE) begin
               cmd.advance = !sts.val_match;
            end else if (sts.key_match) begin
               cmd.set_hit   = 1'b1;
               cmd.upd_value = (sts.func == FUNC_SET);
            end else begin
               cmd.advance = 1'b1;
            end
         end
         ST_ALLOC: cmd.set_full = !sts.free_valid;
         ST_INSERT: cmd.alloc = 1'b1;
         ST_UNLINK: begin
            cmd.unlink   = 1'b1;
            cmd.set_hit0 = 1'b1;
         end
         ST_RESP:  rsp_valid = 1'b1;
         default:  ;
      endcase
   end
endmodule

FILE: src/chte_dpath.sv
// datapath: bucket head and entry pool memories, chain walk registers
`timescale 1ns / 1ps
module chte_dpath #(
   parameter int NUM_BUCKETS  = chte_pkg::DEF_NUM_BUCKETS,
   parameter int POOL_ENTRIES = chte_pkg::DEF_POOL_ENTRIES,
   parameter int KEY_BITS     = chte_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS   = chte_pkg::DEF_VALUE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [chte_pkg::FUNC_W-1:0]    req_func,
   input  logic [chte_pkg::KEY_W-1:0]     req_key,
   input  logic [chte_pkg::VALUE_W-1:0]   req_value,
   output logic [chte_pkg::STATUS_W-1:0]  rsp_status,
   output logic [chte_pkg::VALUE_W-1:0]   rsp_value_out,
   input  chte_pkg::cmd_type              cmd,
   output chte_pkg::sts_type              sts
);
   import chte_pkg::*;

   localparam int BW = $clog2(NUM_BUCKETS);
   localparam int PW = $clog2(POOL_ENTRIES + 1);   // index plus empty marker
   localparam int AW = $clog2(POOL_ENTRIES);
   localparam int IW = (BW > AW) ? BW + 1 : AW + 1;
   localparam int SW = $clog2(POOL_ENTRIES + 1);
   localparam logic [PW-1:0] EMPTY = PW'(POOL_ENTRIES);
   localparam int VW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;

   // memories
   logic [PW-1:0]         head_mem  [NUM_BUCKETS];
   logic [KEY_BITS-1:0]   key_mem   [POOL_ENTRIES];
   logic [VALUE_BITS-1:0] val_mem   [POOL_ENTRIES];
   logic [PW-1:0]         next_mem  [POOL_ENTRIES];

   logic [IW-1:0]         init_ff;
   logic [1:0]            func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [BW-1:0]         bkt_ff;
   logic [PW-1:0]         cur_ff, prev_ff, free_ff;
   logic [PW-1:0]         head_rd_ff;
   logic [KEY_BITS-1:0]   ekey_ff;
   logic [VALUE_BITS-1:0] eval_ff;
   logic [PW-1:0]         enext_ff;
   logic [PW-1:0]         fnext_ff;
   logic [SW-1:0]         steps_ff;
   logic [1:0]            status_ff;
   logic [VALUE_W-1:0]    vout_ff;
   logic                  first_ff;
   logic [AW-1:0]         cur_a, prev_a, free_a;
   logic                  unlink_d_ff;
   logic [PW-1:0]         freed_ff, oldfree_ff;

   assign cur_a  = cur_ff[AW-1:0];
   assign prev_a = prev_ff[AW-1:0];
   assign free_a = free_ff[AW-1:0];

   // init sweep counter covers the larger of the two tables
   always_ff @(posedge clock) begin
      if (reset) init_ff <= '0;
      else if (cmd.init_step && !sts.init_done) init_ff <= init_ff + 1'b1;
   end
   assign sts.init_done = (init_ff >= IW'(NUM_BUCKETS)) && (init_ff >= IW'(POOL_ENTRIES));

   // bucket head memory
   always_ff @(posedge clock) begin
      if (cmd.init_step && init_ff < IW'(NUM_BUCKETS))
         head_mem[init_ff[BW-1:0]] <= EMPTY;
      else if (cmd.alloc)
         head_mem[bkt_ff] <= free_ff;
      else if (cmd.unlink && first_ff)
         head_mem[bkt_ff] <= enext_ff;
      head_rd_ff <= head_mem[bkt_ff];
   end

   // next link memory, one write port, read at cur and at free head
   // freed entry links to old free head, written the cycle after unlink
   always_ff @(posedge clock) begin
      if (cmd.init_step && init_ff < IW'(POOL_ENTRIES))
         next_mem[init_ff[AW-1:0]] <= PW'(init_ff) + 1'b1;
      else if (cmd.alloc)
         next_mem[free_a] <= head_rd_ff;
      else if (cmd.unlink && !first_ff)
         next_mem[prev_a] <= enext_ff;
      else if (unlink_d_ff)
         next_mem[freed_ff[AW-1:0]] <= oldfree_ff;
      enext_ff <= next_mem[cur_a];
      fnext_ff <= next_mem[free_a];
   end

   // capture of the entry being freed and the old free head
   always_ff @(posedge clock) begin
      if (reset) unlink_d_ff <= 1'b0;
      else       unlink_d_ff <= cmd.unlink;
      freed_ff   <= cur_ff;
      oldfree_ff <= free_ff;
   end

   // key and value memories
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         key_mem[free_a] <= key_ff;
         val_mem[free_a] <= val_ff;
      end else if (cmd.upd_value) begin
         val_mem[cur_a] <= val_ff;
      end
      ekey_ff <= key_mem[cur_a];
      eval_ff <= val_mem[cur_a];
   end

   // walk and request registers
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
      end else if (cmd.alloc) begin
         free_ff <= fnext_ff;
      end else if (cmd.unlink) begin
         free_ff <= cur_ff;
      end
      if (cmd.load) begin
         func_ff <= req_func;
         key_ff  <= req_key[KEY_BITS-1:0];
         val_ff  <= VALUE_BITS'(req_value);
         bkt_ff  <= BW'(req_key[31:0]);
         status_ff <= STAT_MISS;
         vout_ff   <= '0;
      end
      if (cmd.head_rd) begin
         first_ff <= 1'b1;
         steps_ff <= '0;
      end
      if (cmd.advance) begin
         prev_ff  <= cur_ff;
         first_ff <= 1'b0;
         steps_ff <= steps_ff + 1'b1;
      end
      if (cmd.set_hit) begin
         status_ff <= STAT_HIT;
         vout_ff   <= VALUE_W'(eval_ff[VW-1:0]);
      end
      if (cmd.set_hit0) status_ff <= STAT_HIT;
      if (cmd.set_full) status_ff <= STAT_FULL;
   end

   // cur takes the bucket head, then follows the next link
   always_ff @(posedge clock) begin
      if (cmd.head_rd)      cur_ff <= head_mem[bkt_ff];
      else if (cmd.advance) cur_ff <= enext_ff;
   end

   // status to controller
   assign sts.cur_valid  = cur_ff < EMPTY;
   assign sts.key_match  = ekey_ff == key_ff;
   assign sts.val_match  = eval_ff == val_ff;
   assign sts.free_valid = free_ff < EMPTY;
   assign sts.steps_done = steps_ff >= SW'(POOL_ENTRIES);
   assign sts.func       = func_ff;

   assign rsp_status    = status_ff;
   assign rsp_value_out = vout_ff;
endmodule

FILE: src/chained_hash_table_engine.sv
// top level: chained hash table engine, controller plus datapath
//
//  channel | ports                                 | direction
//  req     | req_valid req_ready req_func/key/value | in
//  rsp     | rsp_valid rsp_ready rsp_status/value_out | out
//
// each operation reads the bucket head, then walks the chain through the single-port
// entry memories, reading and comparing one entry per step; a set that misses tries to
// allocate and insert, a remove that matches unlinks, and the unused code skips the walk.
// after reset an init sweep over max(NUM_BUCKETS, POOL_ENTRIES) rows runs with
// req_ready low. one operation at a time; a stalled response holds the block.
`timescale 1ns / 1ps
module chained_hash_table_engine #(
   parameter int NUM_BUCKETS  = chte_pkg::DEF_NUM_BUCKETS,
   parameter int POOL_ENTRIES = chte_pkg::DEF_POOL_ENTRIES,
   parameter int KEY_BITS     = chte_pkg::DEF_KEY_BITS,
   parameter int VALUE_BITS   = chte_pkg::DEF_VALUE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [chte_pkg::FUNC_W-1:0]    req_func,
   input  logic [chte_pkg::KEY_W-1:0]     req_key,
   input  logic [chte_pkg::VALUE_W-1:0]   req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [chte_pkg::STATUS_W-1:0]  rsp_status,
   output logic [chte_pkg::VALUE_W-1:0]   rsp_value_out
);
   import chte_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // controller
   chte_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   // datapath
   chte_dpath #(
      .NUM_BUCKETS(NUM_BUCKETS), .POOL_ENTRIES(POOL_ENTRIES),
      .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
   ) u_dpath (
      .clock, .reset, .req_func, .req_key, .req_value,
      .rsp_status, .rsp_value_out, .cmd, .sts
   );

`ifndef SYNTH
   // no request taken while a response is pending
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
   // an accepted beat leads to busy
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("ready after accept");
   // response status never reserved code
   a_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STAT_RSVD)) else $error("bad status");
`endif
endmodule
